// File: hw/rtl/mtk_pkg.sv
// Shared types, constants and character table for the multi-tap text entry block.
package mtk_pkg;

  typedef enum logic [2:0] {
    KIND_PASS     = 3'd0,
    KIND_CONSUMED = 3'd1,
    KIND_WRITTEN  = 3'd2,
    KIND_TEXT     = 3'd3,
    KIND_CANCEL   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CFG_REPEAT_TIMEOUT = 3'd0,
    CFG_DIGIT_ZERO     = 3'd1,
    CFG_MODE_TOGGLE    = 3'd2,
    CFG_FINISH         = 3'd3,
    CFG_CANCEL         = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APPLY,
    ST_READ,
    ST_EMIT
  } state_e;

  localparam int unsigned CodeW = 14;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned NumKeys = 11;
  localparam int unsigned LastTap = 4;

  localparam logic [15:0]      ResetTimeout = 16'd1000;
  localparam logic [CodeW-1:0] ResetDigitZero = 14'd16;
  localparam logic [CodeW-1:0] ResetToggle = 14'd32;
  localparam logic [CodeW-1:0] ResetFinish = 14'd53;
  localparam logic [CodeW-1:0] ResetCancel = 14'd54;

  typedef struct packed {
    logic             operation;
    logic [CodeW-1:0] key_code;
    logic [31:0]      now_ms;
    logic             start_numeric;
  } mtk_in_t;

  typedef struct packed {
    kind_e            kind;
    logic [CodeW-1:0] code_out;
    logic [4:0]       position;
    logic [7:0]       character;
    logic             numeric_now;
    logic             last;
  } mtk_out_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic apply;
    logic walk_start;
    logic walk_read;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_finish;
    logic slot_free;
    logic walk_last;
  } ctrl_sts_t;

  // Row of one key, entry 0 in the low byte.
  function automatic logic [39:0] key_row(input logic [3:0] key);
    logic [39:0] row;
    case (key)
      4'd0:    row = {"0", ";", ":", ",", "."};
      4'd1:    row = {8'd0, 8'd0, "1", " ", "-"};
      4'd2:    row = {8'd0, "2", "c", "b", "a"};
      4'd3:    row = {8'd0, "3", "f", "e", "d"};
      4'd4:    row = {8'd0, "4", "i", "h", "g"};
      4'd5:    row = {8'd0, "5", "l", "k", "j"};
      4'd6:    row = {8'd0, "6", "o", "n", "m"};
      4'd7:    row = {"7", "s", "r", "q", "p"};
      4'd8:    row = {8'd0, "8", "v", "u", "t"};
      4'd9:    row = {"9", "z", "y", "x", "w"};
      4'd10:   row = {8'd0, 8'd0, 8'd0, 8'd0, "-"};
      default: row = '0;
    endcase
    return row;
  endfunction

  function automatic logic [7:0] key_entry(input logic [3:0] key, input logic [2:0] tap);
    logic [39:0] row;
    logic [7:0]  ch;
    row = key_row(key);
    case (tap)
      3'd0:    ch = row[7:0];
      3'd1:    ch = row[15:8];
      3'd2:    ch = row[23:16];
      3'd3:    ch = row[31:24];
      3'd4:    ch = row[39:32];
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // Last nonzero entry of a key's row.
  function automatic logic [7:0] num_entry(input logic [3:0] key);
    logic [39:0] row;
    logic [7:0]  ch;
    row = key_row(key);
    if (row[39:32] != 8'd0)      ch = row[39:32];
    else if (row[31:24] != 8'd0) ch = row[31:24];
    else if (row[23:16] != 8'd0) ch = row[23:16];
    else if (row[15:8] != 8'd0)  ch = row[15:8];
    else                         ch = row[7:0];
    return ch;
  endfunction

endpackage

// File: hw/rtl/mtk_if.sv
// Valid/ready channel interfaces for input items and result items.
interface mtk_in_if;
  logic            valid;
  logic            ready;
  mtk_pkg::mtk_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtk_out_if;
  logic             valid;
  logic             ready;
  mtk_pkg::mtk_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/mtk_ctrl.sv
// Controller state machine: sequences decode, apply and the finish text walk.
module mtk_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtk_pkg::ctrl_sts_t sts_i,
  output mtk_pkg::ctrl_cmd_t cmd_o
);

  mtk_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtk_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      mtk_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = mtk_pkg::ST_DECODE;
        end
      end
      mtk_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = mtk_pkg::ST_APPLY;
      end
      mtk_pkg::ST_APPLY: begin
        if (sts_i.is_finish) begin
          cmd_o.walk_start = 1'b1;
          state_d          = mtk_pkg::ST_READ;
        end else if (sts_i.slot_free) begin
          cmd_o.apply = 1'b1;
          state_d     = mtk_pkg::ST_IDLE;
        end
      end
      mtk_pkg::ST_READ: begin
        cmd_o.walk_read = 1'b1;
        state_d         = mtk_pkg::ST_EMIT;
      end
      mtk_pkg::ST_EMIT: begin
        // hold until the output register can take the character
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.walk_last ? mtk_pkg::ST_IDLE : mtk_pkg::ST_READ;
        end
      end
      default: state_d = mtk_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mtk_dp.sv
// Datapath: configuration, entry state, text memory and output register.
module mtk_dp #(
  parameter int unsigned TEXT_CHARS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [mtk_pkg::CfgW-1:0]    cfg_data_i,
  input  mtk_pkg::mtk_in_t            in_data_i,
  input  mtk_pkg::ctrl_cmd_t          cmd_i,
  output mtk_pkg::ctrl_sts_t          sts_o,
  output logic                        out_valid_o,
  output mtk_pkg::mtk_out_t           out_data_o,
  input  logic                        out_ready_i
);

  localparam int unsigned AW = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;
  localparam int unsigned CW = $clog2(TEXT_CHARS + 1);
  localparam int unsigned CodeW = mtk_pkg::CodeW;

  typedef enum logic [2:0] {
    CLS_START,
    CLS_PASS,
    CLS_TOGGLE,
    CLS_CANCEL,
    CLS_FINISH,
    CLS_IGNORE,
    CLS_DIGIT
  } cls_e;

  logic [15:0]      timeout_q;
  logic [CodeW-1:0] dzero_q, toggle_q, finish_q, cancel_q;

  mtk_pkg::mtk_in_t in_q;
  logic              active_q, mode_q;
  logic [CW-1:0]     cs_q;
  logic [2:0]        tap_q;
  logic [CodeW-1:0]  prev_code_q;
  logic [31:0]       prev_time_q;
  logic [TEXT_CHARS-1:0] valid_q;
  logic [7:0]        mem [TEXT_CHARS];
  logic [7:0]        rd_q;
  logic [AW-1:0]     idx_q;

  cls_e              cls_q, cls_d;
  logic [3:0]        key_q;
  logic              rpt_q;

  logic              out_valid_q;
  mtk_pkg::mtk_out_t out_q, out_d;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= mtk_pkg::ResetTimeout;
      dzero_q   <= mtk_pkg::ResetDigitZero;
      toggle_q  <= mtk_pkg::ResetToggle;
      finish_q  <= mtk_pkg::ResetFinish;
      cancel_q  <= mtk_pkg::ResetCancel;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mtk_pkg::CFG_REPEAT_TIMEOUT: timeout_q <= cfg_data_i;
        mtk_pkg::CFG_DIGIT_ZERO:     dzero_q   <= cfg_data_i[CodeW-1:0];
        mtk_pkg::CFG_MODE_TOGGLE:    toggle_q  <= cfg_data_i[CodeW-1:0];
        mtk_pkg::CFG_FINISH:         finish_q  <= cfg_data_i[CodeW-1:0];
        mtk_pkg::CFG_CANCEL:         cancel_q  <= cfg_data_i[CodeW-1:0];
        default: ;
      endcase
    end
  end

  // Decode stage
  logic [CodeW-1:0] key_diff;
  logic [31:0]      elapsed;
  logic             rpt_d;

  always_comb begin
    key_diff = in_q.key_code - dzero_q;
    elapsed  = in_q.now_ms - prev_time_q;
    rpt_d    = (elapsed <= {16'd0, timeout_q}) && (in_q.key_code == prev_code_q);
    if (!in_q.operation)                          cls_d = CLS_START;
    else if (!active_q)                           cls_d = CLS_PASS;
    else if (in_q.key_code == toggle_q)           cls_d = CLS_TOGGLE;
    else if (in_q.key_code == cancel_q)           cls_d = CLS_CANCEL;
    else if (in_q.key_code == finish_q)           cls_d = CLS_FINISH;
    else if (in_q.key_code == '0)                 cls_d = CLS_IGNORE;
    else if (key_diff > CodeW'(mtk_pkg::NumKeys - 1)) cls_d = CLS_IGNORE;
    else                                          cls_d = CLS_DIGIT;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
    if (cmd_i.decode) begin
      key_q <= key_diff[3:0];
      rpt_q <= rpt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= CLS_IGNORE;
    end else if (cmd_i.decode) begin
      cls_q <= cls_d;
    end
  end

  // Digit write path
  logic [2:0]    tap_inc, tap_cap, tap_d;
  logic [7:0]    wr_char;
  logic [CW-1:0] cs_inc, cs_d, pos_cs;
  logic [AW-1:0] wr_addr;

  always_comb begin
    tap_inc = rpt_q ? tap_q + 3'd1 : 3'd0;
    tap_cap = (tap_inc > 3'(mtk_pkg::LastTap)) ? 3'd0 : tap_inc;
    tap_d   = (mtk_pkg::key_entry(key_q, tap_cap) == 8'd0) ? 3'd0 : tap_cap;
    wr_char = mode_q ? mtk_pkg::num_entry(key_q) : mtk_pkg::key_entry(key_q, tap_d);
    cs_inc  = (!rpt_q && (cs_q < CW'(TEXT_CHARS))) ? cs_q + CW'(1) : cs_q;
    cs_d    = (cs_inc == '0) ? CW'(1) : cs_inc;
    pos_cs  = cs_d - CW'(1);
    wr_addr = pos_cs[AW-1:0];
  end

  logic digit_we, clear_all;
  assign digit_we  = cmd_i.apply && (cls_q == CLS_DIGIT);
  assign clear_all = (cmd_i.apply && (cls_q == CLS_CANCEL)) || (cmd_i.emit && sts_o.walk_last);

  // Text memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (digit_we) mem[wr_addr] <= wr_char;
    if (cmd_i.walk_read) rd_q <= mem[idx_q];
  end

  // Entry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      mode_q      <= 1'b0;
      cs_q        <= '0;
      tap_q       <= '0;
      prev_code_q <= '0;
      prev_time_q <= '0;
      valid_q     <= '0;
      idx_q       <= '0;
    end else begin
      if (cmd_i.apply) begin
        case (cls_q)
          CLS_START: begin
            active_q <= 1'b1;
            mode_q   <= in_q.start_numeric;
            cs_q     <= '0;
          end
          CLS_TOGGLE: mode_q <= ~mode_q;
          CLS_DIGIT: begin
            cs_q             <= cs_d;
            tap_q            <= tap_d;
            prev_code_q      <= mode_q ? '0 : in_q.key_code;
            prev_time_q      <= in_q.now_ms;
            valid_q[wr_addr] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd_i.walk_start) idx_q <= '0;
      if (cmd_i.emit && !sts_o.walk_last) idx_q <= idx_q + AW'(1);
      // close the session and drop the text
      if (clear_all) begin
        active_q <= 1'b0;
        cs_q     <= '0;
        valid_q  <= '0;
      end
    end
  end

  // Walk status
  logic [31:0] idx32, pos32;
  logic        idx_end;

  always_comb begin
    idx32   = 32'(idx_q);
    pos32   = 32'(pos_cs);
    idx_end = (idx32 == 32'(TEXT_CHARS - 1));
    sts_o.is_finish = (cls_q == CLS_FINISH);
    sts_o.slot_free = !out_valid_q || out_ready_i;
    sts_o.walk_last = !valid_q[idx_q] || idx_end || !valid_q[idx_q + AW'(1)];
  end

  // Result assembly
  always_comb begin
    out_d             = '0;
    out_d.numeric_now = mode_q;
    out_d.last        = 1'b1;
    out_d.kind        = mtk_pkg::KIND_CONSUMED;
    if (cmd_i.emit) begin
      out_d.kind      = mtk_pkg::KIND_TEXT;
      out_d.position  = idx32[4:0];
      out_d.character = valid_q[idx_q] ? rd_q : 8'd0;
      out_d.last      = sts_o.walk_last;
    end else begin
      case (cls_q)
        CLS_START:  out_d.numeric_now = in_q.start_numeric;
        CLS_PASS: begin
          out_d.kind     = mtk_pkg::KIND_PASS;
          out_d.code_out = in_q.key_code;
        end
        CLS_TOGGLE: out_d.numeric_now = ~mode_q;
        CLS_CANCEL: out_d.kind = mtk_pkg::KIND_CANCEL;
        CLS_DIGIT: begin
          out_d.kind      = mtk_pkg::KIND_WRITTEN;
          out_d.position  = pos32[4:0];
          out_d.character = wr_char;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.apply || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply || cmd_i.emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/multitap_keypad_text_entry.sv
// Multi-tap text entry from remote-control key codes. A start item opens a session; key items
// pass through outside a session, and inside one toggle mode, write characters from the keypad
// table, cancel, finish, or are ignored. Every item other than finish goes through accept, decode
// and apply before its result is in the output register, and apply waits while that register is
// full, so a new item is taken only after the previous one is applied. Finish emits the stored text
// one character at a time (at least one), each read through the single registered read port of
// the text memory, and no new item is taken until the last character is emitted.
// The text store has a valid bit per position that reset, finish and cancel clear at once.
// A new item is accepted while the previous result still waits in the output register.
module multitap_keypad_text_entry #(
  parameter int unsigned TEXT_CHARS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [mtk_pkg::CfgW-1:0] cfg_data_i,
  mtk_in_if.sink                   in_i,
  mtk_out_if.source                out_o
);

  mtk_pkg::ctrl_cmd_t cmd;
  mtk_pkg::ctrl_sts_t sts;

  mtk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtk_dp #(
    .TEXT_CHARS (TEXT_CHARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

  // Commands are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.decode, cmd.apply, cmd.walk_start, cmd.walk_read, cmd.emit}))
    else $error("controller issued more than one command");

  // No result is loaded over one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.apply || cmd.emit) |-> sts.slot_free)
    else $error("output register overwritten");

  // An accepted item blocks the input until it is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while an item is in progress");

  // Emitted and written positions stay inside the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_o.data.position) < 32'(TEXT_CHARS)) || (TEXT_CHARS > 32))
    else $error("position beyond text length");

endmodule
